[rtl/call_stack_and_opcode_profiler_assert.svh]
// Assertion macros used by the checker file.
`ifndef CALL_STACK_AND_OPCODE_PROFILER_ASSERT_SVH
`define CALL_STACK_AND_OPCODE_PROFILER_ASSERT_SVH

// Same-cycle implication.
`define CSOP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define CSOP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/csop_pkg.sv]
package csop_pkg;

  localparam int STACK_DEPTH_DEF   = 32;
  localparam int FUNCTION_IDS_DEF  = 64;
  localparam int COUNTER_WIDTH_DEF = 48;
  localparam int PAIR_ENTRIES_DEF  = 65536;

  localparam int TS_W = 48;
  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_OP   = 2'd0,
    FUNC_ENT  = 2'd1,
    FUNC_EXIT = 2'd2,
    FUNC_UNW  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_OP    = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_EXIT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_ENT1,
    S_ENT2,
    S_POPA,
    S_POPB,
    S_POPC,
    S_POPD,
    S_EMIT
  } state_e;

  typedef struct packed {
    kind_e        kind;
    logic [47:0]  count;
    logic [47:0]  pair_value;
    logic         pair_valid;
    logic [5:0]   closed;
    logic [47:0]  elapsed;
    logic [47:0]  self_t;
    logic [47:0]  total;
    logic         mismatch;
    logic         overflow;
    logic         last;
  } result_t;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] max);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, max}) ? max : s[63:0];
  endfunction

endpackage

[rtl/call_stack_and_opcode_profiler.sv]
// An opcode passes S_OP, an entry S_ENT1 and S_ENT2, and each frame popped by an exit
// or unwind S_POPA, S_POPB, S_POPC and, in full mode with a parent, S_POPD, before
// S_EMIT loads the output register; an exit on an empty stack or unwind with nothing
// to pop goes straight to S_EMIT. One item at a time; a stalled output holds it.
// After reset a clearing pass over max(PAIR_ENTRIES, FUNCTION_IDS**2) addresses zeroes
// all counter memories; no item is accepted during it, configuration writes are.
module call_stack_and_opcode_profiler #(
  parameter int STACK_DEPTH   = csop_pkg::STACK_DEPTH_DEF,
  parameter int FUNCTION_IDS  = csop_pkg::FUNCTION_IDS_DEF,
  parameter int COUNTER_WIDTH = csop_pkg::COUNTER_WIDTH_DEF,
  parameter int PAIR_ENTRIES  = csop_pkg::PAIR_ENTRIES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i,      // full_mode
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,    // opcode, function_id, timestamp, target_depth
  input  logic [1:0]   s_axis_tuser,    // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // count_value, pair_value, pair_valid, closed_function, elapsed_time,
  // self_time, function_total, mismatch, overflow
  output logic [255:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser,    // kind
  output logic         m_axis_tlast
);

  localparam int CW     = COUNTER_WIDTH;
  localparam int FID_W  = $clog2(FUNCTION_IDS);
  localparam int EDGE_N = FUNCTION_IDS * FUNCTION_IDS;
  localparam int EDGE_W = $clog2(EDGE_N);
  localparam int SP_W   = $clog2(STACK_DEPTH);
  localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
  localparam int PAIR_W = $clog2(PAIR_ENTRIES);
  localparam int TS_W   = csop_pkg::TS_W;
  localparam int ST_W   = FID_W + 2 * TS_W;
  localparam int CLR_N  = (PAIR_ENTRIES > EDGE_N) ? PAIR_ENTRIES : EDGE_N;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - CW);

  function automatic logic [EDGE_W-1:0] edge_idx(logic [FID_W-1:0] a,
                                                 logic [FID_W-1:0] b);
    return EDGE_W'(32'(a) * FUNCTION_IDS + 32'(b));
  endfunction

  logic [FID_W-1:0] fid_lut [64];
  for (genvar g = 0; g < 64; g++) begin : g_fid
    assign fid_lut[g] = FID_W'(g % FUNCTION_IDS);
  end

  csop_pkg::state_e  state_q, state_d;
  logic [DEP_W-1:0]  depth_q;
  logic [7:0]        prev_op_q;
  logic              prev_vld_q;
  logic              full_mode_q;
  logic              out_valid_q;

  csop_pkg::func_e   func_q;
  logic [7:0]        op_q;
  logic [FID_W-1:0]  fid_q;
  logic [TS_W-1:0]   now_q;
  logic [5:0]        tgt_q;
  logic [FID_W-1:0]  top_id_q;
  logic [TS_W-1:0]   elapsed_q;
  logic [TS_W-1:0]   child_q;
  logic [EDGE_W-1:0] edge_addr_q;
  csop_pkg::result_t res_q, out_q;

  logic              clr_active;
  logic [CLR_W-1:0]  clr_addr;

  logic              op_we, op_re;
  logic [7:0]        op_waddr, op_raddr;
  logic [CW-1:0]     op_wdata, op_rdata;
  logic              pr_we, pr_re;
  logic [PAIR_W-1:0] pr_waddr, pr_raddr;
  logic [CW-1:0]     pr_wdata, pr_rdata;
  logic              st_we, st_re;
  logic [SP_W-1:0]   st_waddr, st_raddr;
  logic [ST_W-1:0]   st_wdata, st_rdata;
  logic              fn_we, fn_re;
  logic [FID_W-1:0]  fn_waddr, fn_raddr;
  logic [3*CW-1:0]   fn_wdata, fn_rdata;
  logic              ed_we, ed_re;
  logic [EDGE_W-1:0] ed_waddr, ed_raddr;
  logic [2*CW-1:0]   ed_wdata, ed_rdata;

  csop_clear #(.N(CLR_N)) u_clear (
    .clk_i, .rst_ni, .active_o(clr_active), .addr_o(clr_addr)
  );

  csop_ram #(.WIDTH(CW), .DEPTH(256)) u_op_ram (
    .clk_i, .we_i(op_we), .waddr_i(op_waddr), .wdata_i(op_wdata),
    .re_i(op_re), .raddr_i(op_raddr), .rdata_o(op_rdata)
  );
  csop_ram #(.WIDTH(CW), .DEPTH(PAIR_ENTRIES)) u_pair_ram (
    .clk_i, .we_i(pr_we), .waddr_i(pr_waddr), .wdata_i(pr_wdata),
    .re_i(pr_re), .raddr_i(pr_raddr), .rdata_o(pr_rdata)
  );
  csop_ram #(.WIDTH(ST_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .re_i(st_re), .raddr_i(st_raddr), .rdata_o(st_rdata)
  );
  csop_ram #(.WIDTH(3 * CW), .DEPTH(FUNCTION_IDS)) u_func_ram (
    .clk_i, .we_i(fn_we), .waddr_i(fn_waddr), .wdata_i(fn_wdata),
    .re_i(fn_re), .raddr_i(fn_raddr), .rdata_o(fn_rdata)
  );
  csop_ram #(.WIDTH(2 * CW), .DEPTH(EDGE_N)) u_edge_ram (
    .clk_i, .we_i(ed_we), .waddr_i(ed_waddr), .wdata_i(ed_wdata),
    .re_i(ed_re), .raddr_i(ed_raddr), .rdata_o(ed_rdata)
  );

  csop_pkg::func_e  in_func;
  logic [7:0]       in_op;
  logic [FID_W-1:0] in_fid;
  logic [TS_W-1:0]  in_now;
  logic [5:0]       in_tgt;
  logic             in_fire, out_free;

  assign in_func = csop_pkg::func_e'(s_axis_tuser);
  assign in_op   = s_axis_tdata[7:0];
  assign in_fid  = fid_lut[s_axis_tdata[13:8]];
  assign in_now  = s_axis_tdata[61:14];
  assign in_tgt  = s_axis_tdata[67:62];

  assign s_axis_tready = (state_q == csop_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  logic [FID_W-1:0] st_id;
  logic [TS_W-1:0]  st_start, st_child;
  logic [CW-1:0]    fn_calls, fn_total, fn_self, ed_cnt, ed_time;
  logic [CW-1:0]    op_new, pr_new, call_new, ed_new, tot_new, selfacc_new, ed_time_new;
  logic [TS_W-1:0]  self_v, child_new, elapsed_v;
  logic [DEP_W-1:0] depth_m1;
  logic [SP_W-1:0]  top_addr, par_addr, push_addr;
  logic             has_parent, stack_full, edge_en, more_pops, in_pops;

  assign st_id    = st_rdata[FID_W-1:0];
  assign st_start = st_rdata[FID_W +: TS_W];
  assign st_child = st_rdata[FID_W + TS_W +: TS_W];
  assign fn_calls = fn_rdata[0 +: CW];
  assign fn_total = fn_rdata[CW +: CW];
  assign fn_self  = fn_rdata[2 * CW +: CW];
  assign ed_cnt   = ed_rdata[0 +: CW];
  assign ed_time  = ed_rdata[CW +: CW];

  assign op_new      = CW'(csop_pkg::sat_add(64'(op_rdata), 64'd1, CNT_MAX));
  assign pr_new      = CW'(csop_pkg::sat_add(64'(pr_rdata), 64'd1, CNT_MAX));
  assign call_new    = CW'(csop_pkg::sat_add(64'(fn_calls), 64'd1, CNT_MAX));
  assign ed_new      = CW'(csop_pkg::sat_add(64'(ed_cnt), 64'd1, CNT_MAX));
  assign self_v      = (elapsed_q > child_q) ? (elapsed_q - child_q) : '0;
  assign tot_new     = CW'(csop_pkg::sat_add(64'(fn_total), 64'(elapsed_q), CNT_MAX));
  assign selfacc_new = CW'(csop_pkg::sat_add(64'(fn_self), 64'(self_v), CNT_MAX));
  assign ed_time_new = CW'(csop_pkg::sat_add(64'(ed_time), 64'(elapsed_q), CNT_MAX));
  assign child_new   = TS_W'(csop_pkg::sat_add(64'(st_child), 64'(elapsed_q),
                                               csop_pkg::MASK48));
  assign elapsed_v   = now_q - st_start;

  assign depth_m1   = depth_q - DEP_W'(1);
  assign top_addr   = SP_W'(depth_m1);
  assign par_addr   = SP_W'(depth_q - DEP_W'(2));
  assign push_addr  = SP_W'(depth_q);
  assign has_parent = depth_q > DEP_W'(1);
  assign stack_full = 8'(depth_q) >= 8'(STACK_DEPTH);
  assign edge_en    = full_mode_q && (depth_q != '0);
  assign more_pops  = (func_q == csop_pkg::FUNC_UNW) && (8'(depth_q) > 8'(tgt_q));
  assign in_pops    = 8'(depth_q) > 8'(in_tgt);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csop_pkg::S_CLEAR: begin
        if (!clr_active) state_d = csop_pkg::S_IDLE;
      end
      csop_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_func)
            csop_pkg::FUNC_OP:   state_d = csop_pkg::S_OP;
            csop_pkg::FUNC_ENT:  state_d = csop_pkg::S_ENT1;
            csop_pkg::FUNC_EXIT: state_d = (depth_q == '0) ? csop_pkg::S_EMIT
                                                           : csop_pkg::S_POPA;
            csop_pkg::FUNC_UNW:  state_d = in_pops ? csop_pkg::S_POPA
                                                   : csop_pkg::S_EMIT;
          endcase
        end
      end
      csop_pkg::S_OP:   state_d = csop_pkg::S_EMIT;
      csop_pkg::S_ENT1: state_d = csop_pkg::S_ENT2;
      csop_pkg::S_ENT2: state_d = csop_pkg::S_EMIT;
      csop_pkg::S_POPA: state_d = csop_pkg::S_POPB;
      csop_pkg::S_POPB: state_d = csop_pkg::S_POPC;
      csop_pkg::S_POPC: state_d = (full_mode_q && has_parent) ? csop_pkg::S_POPD
                                                              : csop_pkg::S_EMIT;
      csop_pkg::S_POPD: state_d = csop_pkg::S_EMIT;
      csop_pkg::S_EMIT: begin
        if (out_free) state_d = more_pops ? csop_pkg::S_POPA : csop_pkg::S_IDLE;
      end
      default: state_d = csop_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    op_we = 1'b0; op_waddr = '0; op_wdata = '0; op_re = 1'b0; op_raddr = '0;
    pr_we = 1'b0; pr_waddr = '0; pr_wdata = '0; pr_re = 1'b0; pr_raddr = '0;
    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_re = 1'b0; st_raddr = '0;
    fn_we = 1'b0; fn_waddr = '0; fn_wdata = '0; fn_re = 1'b0; fn_raddr = '0;
    ed_we = 1'b0; ed_waddr = '0; ed_wdata = '0; ed_re = 1'b0; ed_raddr = '0;
    unique case (state_q)
      csop_pkg::S_CLEAR: begin
        op_we = clr_active; op_waddr = 8'(clr_addr);
        pr_we = clr_active; pr_waddr = PAIR_W'(clr_addr);
        fn_we = clr_active; fn_waddr = FID_W'(clr_addr);
        ed_we = clr_active; ed_waddr = EDGE_W'(clr_addr);
      end
      csop_pkg::S_IDLE: begin
        if (in_fire && in_func == csop_pkg::FUNC_OP) begin
          op_re = 1'b1; op_raddr = in_op;
          pr_re = 1'b1; pr_raddr = PAIR_W'({prev_op_q, in_op});
        end
        if (in_fire && in_func == csop_pkg::FUNC_ENT) begin
          st_re = 1'b1; st_raddr = top_addr;
          fn_re = 1'b1; fn_raddr = in_fid;
        end
      end
      csop_pkg::S_OP: begin
        op_we = 1'b1; op_waddr = op_q; op_wdata = op_new;
        pr_we = prev_vld_q; pr_waddr = PAIR_W'({prev_op_q, op_q}); pr_wdata = pr_new;
      end
      csop_pkg::S_ENT1: begin
        ed_re = 1'b1; ed_raddr = edge_idx(st_id, fid_q);
      end
      csop_pkg::S_ENT2: begin
        ed_we = edge_en; ed_waddr = edge_addr_q; ed_wdata = {ed_time, ed_new};
        fn_we = 1'b1; fn_waddr = fid_q; fn_wdata = {fn_self, fn_total, call_new};
        st_we = !stack_full; st_waddr = push_addr;
        st_wdata = {{TS_W{1'b0}}, now_q, fid_q};
      end
      csop_pkg::S_POPA: begin
        st_re = 1'b1; st_raddr = top_addr;
      end
      csop_pkg::S_POPB: begin
        fn_re = 1'b1; fn_raddr = st_id;
        st_re = 1'b1; st_raddr = par_addr;
      end
      csop_pkg::S_POPC: begin
        fn_we = 1'b1; fn_waddr = top_id_q; fn_wdata = {selfacc_new, tot_new, fn_calls};
        st_we = has_parent; st_waddr = par_addr; st_wdata = {child_new, st_start, st_id};
        ed_re = full_mode_q && has_parent; ed_raddr = edge_idx(st_id, top_id_q);
      end
      csop_pkg::S_POPD: begin
        ed_we = (ed_cnt != '0); ed_waddr = edge_addr_q; ed_wdata = {ed_time_new, ed_cnt};
      end
      csop_pkg::S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csop_pkg::S_CLEAR;
      depth_q     <= '0;
      prev_op_q   <= '0;
      prev_vld_q  <= 1'b0;
      full_mode_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) full_mode_q <= cfg_data_i;
      if (in_fire && (in_func == csop_pkg::FUNC_ENT || in_func == csop_pkg::FUNC_EXIT ||
                      (in_func == csop_pkg::FUNC_UNW && in_pops))) begin
        prev_vld_q <= 1'b0;
      end
      if (state_q == csop_pkg::S_OP) begin
        prev_op_q  <= op_q;
        prev_vld_q <= 1'b1;
      end
      if (state_q == csop_pkg::S_ENT2 && !stack_full) depth_q <= depth_q + DEP_W'(1);
      if (state_q == csop_pkg::S_POPC) depth_q <= depth_m1;
      if (state_q == csop_pkg::S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= in_func;
      op_q   <= in_op;
      fid_q  <= in_fid;
      now_q  <= in_now;
      tgt_q  <= in_tgt;
      res_q  <= '{kind: csop_pkg::KIND_NONE, last: 1'b1, default: '0};
    end
    unique case (state_q)
      csop_pkg::S_OP: begin
        res_q <= '{kind: csop_pkg::KIND_OP, count: 48'(op_new),
                   pair_value: prev_vld_q ? 48'(pr_new) : 48'd0,
                   pair_valid: prev_vld_q, last: 1'b1, default: '0};
      end
      csop_pkg::S_ENT1: begin
        edge_addr_q <= edge_idx(st_id, fid_q);
      end
      csop_pkg::S_ENT2: begin
        res_q <= '{kind: csop_pkg::KIND_ENTRY, count: 48'(call_new),
                   pair_value: edge_en ? 48'(ed_new) : 48'd0,
                   pair_valid: edge_en, overflow: stack_full, last: 1'b1,
                   default: '0};
      end
      csop_pkg::S_POPB: begin
        top_id_q  <= st_id;
        elapsed_q <= elapsed_v;
        child_q   <= st_child;
      end
      csop_pkg::S_POPC: begin
        edge_addr_q <= edge_idx(st_id, top_id_q);
        res_q <= '{kind: csop_pkg::KIND_EXIT, closed: 6'(top_id_q),
                   elapsed: elapsed_q, self_t: self_v, total: 48'(tot_new),
                   mismatch: (func_q == csop_pkg::FUNC_EXIT) && (fid_q != top_id_q),
                   last: (func_q != csop_pkg::FUNC_UNW) ||
                         (8'(depth_m1) <= 8'(tgt_q)),
                   default: '0};
      end
      csop_pkg::S_EMIT: begin
        if (out_free) out_q <= res_q;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'd0, out_q.overflow, out_q.mismatch, out_q.total,
                          out_q.self_t, out_q.elapsed, out_q.closed,
                          out_q.pair_valid, out_q.pair_value, out_q.count};

endmodule

[rtl/csop_ram.sv]
module csop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/csop_clear.sv]
module csop_clear #(
  parameter int N = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 active_o,
  output logic [$clog2(N)-1:0] addr_o
);

  localparam int AW = $clog2(N);

  logic [AW-1:0] cnt_q;
  logic          active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b1;
    end else if (active_q) begin
      if (cnt_q == AW'(N - 1)) begin
        active_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + AW'(1);
      end
    end
  end

  assign active_o = active_q;
  assign addr_o   = cnt_q;

endmodule

[rtl/csop_checker.sv]
`include "call_stack_and_opcode_profiler_assert.svh"

module csop_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);

  logic         out_stall, none_beat, none_ok, single_beat, no_pair;
  logic [258:0] out_word;

  assign out_stall   = m_axis_tvalid && !m_axis_tready;
  assign out_word    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign none_beat   = m_axis_tvalid && (m_axis_tuser == csop_pkg::KIND_NONE);
  assign none_ok     = (m_axis_tdata == 256'd0) && m_axis_tlast;
  assign single_beat = m_axis_tvalid && (m_axis_tuser == csop_pkg::KIND_OP ||
                                         m_axis_tuser == csop_pkg::KIND_ENTRY);
  assign no_pair     = m_axis_tvalid && !m_axis_tdata[96];

  `CSOP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_word))
  `CSOP_ASSERT_IMPL(a_none_zero, clk_i, rst_ni, none_beat, none_ok)
  `CSOP_ASSERT_IMPL(a_single_last, clk_i, rst_ni, single_beat, m_axis_tlast)
  `CSOP_ASSERT_IMPL(a_pair_zero, clk_i, rst_ni, no_pair, m_axis_tdata[95:48] == 48'd0)

endmodule

bind call_stack_and_opcode_profiler csop_checker u_csop_checker (.*);

[verif/tb_call_stack_and_opcode_profiler.sv]
module tb_call_stack_and_opcode_profiler;

  localparam int NSTACK = 32;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic         cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [255:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  call_stack_and_opcode_profiler DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  // profiler shadow state
  logic        full_mode;
  logic [47:0] op_count [256];
  logic [47:0] pair_count [int];
  logic [7:0]  prev_op;
  logic        prev_seen;
  logic [5:0]  frame_id [NSTACK];
  logic [47:0] frame_start [NSTACK];
  logic [47:0] frame_child [NSTACK];
  int          depth;
  logic [47:0] calls [64];
  logic [47:0] tot_time [64];
  logic [47:0] self_acc [64];
  logic [47:0] edge_calls [int];
  logic [47:0] edge_time [int];

  csop_pkg::result_t pending_results[$];
  int                errors;
  int                burst_left;
  logic [47:0]       now_ts;

  function automatic void enqueue_result(csop_pkg::result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic csop_pkg::result_t blank_result(csop_pkg::kind_e k);
    csop_pkg::result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic csop_pkg::result_t pop_frame(logic [5:0] exit_id, logic [47:0] ts);
    csop_pkg::result_t r;
    int top;
    logic [5:0] id;
    logic [47:0] el, sf;
    int e;
    top = depth - 1;
    id = frame_id[top];
    el = ts - frame_start[top];
    sf = (el > frame_child[top]) ? el - frame_child[top] : '0;
    depth = top;
    tot_time[id] = sat48(tot_time[id], el);
    self_acc[id] = sat48(self_acc[id], sf);
    if (depth > 0) begin
      frame_child[depth-1] = sat48(frame_child[depth-1], el);
      if (full_mode) begin
        e = {frame_id[depth-1], id};
        if (edge_calls.exists(e) && edge_calls[e] != 0)
          edge_time[e] = sat48(edge_time.exists(e) ? edge_time[e] : 48'd0, el);
      end
    end
    r = blank_result(csop_pkg::KIND_EXIT);
    r.closed = id;
    r.elapsed = el;
    r.self_t = sf;
    r.total = tot_time[id];
    r.mismatch = (exit_id != id);
    return r;
  endfunction

  function automatic void profile_step(csop_pkg::func_e f, logic [7:0] op, logic [5:0] fid,
                                       logic [47:0] ts, logic [5:0] tgt);
    csop_pkg::result_t r;
    int k, e, n;
    case (f)
      csop_pkg::FUNC_OP: begin
        r = blank_result(csop_pkg::KIND_OP);
        op_count[op] = sat48(op_count[op], 48'd1);
        r.count = op_count[op];
        if (prev_seen) begin
          k = {prev_op, op};
          pair_count[k] = sat48(pair_count.exists(k) ? pair_count[k] : 48'd0, 48'd1);
          r.pair_value = pair_count[k];
          r.pair_valid = 1'b1;
        end
        prev_op = op;
        prev_seen = 1'b1;
        r.last = 1'b1;
        enqueue_result(r);
      end
      csop_pkg::FUNC_ENT: begin
        r = blank_result(csop_pkg::KIND_ENTRY);
        prev_seen = 1'b0;
        if (full_mode && depth > 0) begin
          e = {frame_id[depth-1], fid};
          edge_calls[e] = sat48(edge_calls.exists(e) ? edge_calls[e] : 48'd0, 48'd1);
          r.pair_value = edge_calls[e];
          r.pair_valid = 1'b1;
        end
        if (depth >= NSTACK) begin
          r.overflow = 1'b1;
        end else begin
          frame_id[depth] = fid;
          frame_start[depth] = ts;
          frame_child[depth] = '0;
          depth++;
        end
        calls[fid] = sat48(calls[fid], 48'd1);
        r.count = calls[fid];
        r.last = 1'b1;
        enqueue_result(r);
      end
      csop_pkg::FUNC_EXIT: begin
        prev_seen = 1'b0;
        if (depth == 0) r = blank_result(csop_pkg::KIND_NONE);
        else r = pop_frame(fid, ts);
        r.last = 1'b1;
        enqueue_result(r);
      end
      default: begin
        n = 0;
        while (depth > tgt && n < NSTACK) begin
          prev_seen = 1'b0;
          r = pop_frame(frame_id[depth-1], ts);
          n++;
          r.last = !(depth > tgt && n < NSTACK);
          enqueue_result(r);
        end
        if (n == 0) begin
          r = blank_result(csop_pkg::KIND_NONE);
          r.last = 1'b1;
          enqueue_result(r);
        end
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    csop_pkg::result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind       = csop_pkg::kind_e'(m_axis_tuser);
      got.count      = m_axis_tdata[47:0];
      got.pair_value = m_axis_tdata[95:48];
      got.pair_valid = m_axis_tdata[96];
      got.closed     = m_axis_tdata[102:97];
      got.elapsed    = m_axis_tdata[150:103];
      got.self_t     = m_axis_tdata[198:151];
      got.total      = m_axis_tdata[246:199];
      got.mismatch   = m_axis_tdata[247];
      got.overflow   = m_axis_tdata[248];
      got.last       = m_axis_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind != want.kind || got.count != want.count
            || got.pair_value != want.pair_value || got.pair_valid != want.pair_valid
            || got.closed != want.closed || got.elapsed != want.elapsed
            || got.self_t != want.self_t || got.total != want.total
            || got.mismatch != want.mismatch || got.overflow != want.overflow
            || got.last != want.last || m_axis_tdata[255:249] != '0) begin
          errors++;
          if (errors <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // receiver stall pattern: a random ready percentage, redrawn whenever rx_cnt runs out
  int rx_pct, rx_cnt;
  always @(posedge clk_i) begin
    if (rx_cnt == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pct = 100;
        1: rx_pct = 75;
        2: rx_pct = 40;
        default: rx_pct = 10;
      endcase
      rx_cnt = 64;
    end
    rx_cnt--;
    m_axis_tready <= ($urandom_range(0, 99) < rx_pct);
  end

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  task automatic send_event(csop_pkg::func_e f, logic [7:0] op, logic [5:0] fid,
                            logic [47:0] ts, logic [5:0] tgt);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {4'b0, tgt, ts, fid, op};
    do @(posedge clk_i); while (!s_axis_tready);
    profile_step(f, op, fid, ts, tgt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    full_mode = v;
  endtask

  function automatic logic [47:0] tick();
    if ($urandom_range(0, 19) == 0) now_ts = rand48();
    else now_ts = now_ts + $urandom_range(0, 300);
    return now_ts;
  endfunction

  task automatic test_directed();
    send_event(csop_pkg::FUNC_EXIT, 8'hFF, 6'd63, MAX48, 6'd0);
    send_event(csop_pkg::FUNC_UNW, 8'hFF, 6'd63, MAX48, 6'd63);
    send_event(csop_pkg::FUNC_OP, 8'h00, 6'd0, 48'd0, 6'd0);
    send_event(csop_pkg::FUNC_OP, 8'hFF, 6'd63, MAX48, 6'd63);
    send_event(csop_pkg::FUNC_OP, 8'hFF, 6'd0, 48'd0, 6'd0);
    send_event(csop_pkg::FUNC_OP, 8'hA5, 6'd21, 48'h5555_5555_5555, 6'd42);
    send_event(csop_pkg::FUNC_ENT, 8'h5A, 6'd0, MAX48 - 48'd10, 6'd21);
    send_event(csop_pkg::FUNC_OP, 8'h01, 6'd0, 48'd0, 6'd0);
    send_event(csop_pkg::FUNC_ENT, 8'h00, 6'd63, MAX48, 6'd0);
    send_event(csop_pkg::FUNC_ENT, 8'h00, 6'd42, 48'd20, 6'd0);
    send_event(csop_pkg::FUNC_EXIT, 8'h00, 6'd42, 48'd25, 6'd0);
    send_event(csop_pkg::FUNC_EXIT, 8'h00, 6'd5, 48'd30, 6'd0);
    send_event(csop_pkg::FUNC_ENT, 8'h00, 6'd63, 48'd40, 6'd0);
    send_event(csop_pkg::FUNC_ENT, 8'h00, 6'd0, 48'd45, 6'd0);
    send_event(csop_pkg::FUNC_UNW, 8'h00, 6'd0, 48'd100, 6'd63);
    send_event(csop_pkg::FUNC_UNW, 8'h00, 6'd0, 48'd200, 6'd1);
    send_event(csop_pkg::FUNC_OP, 8'h80, 6'd0, 48'd0, 6'd0);
    send_event(csop_pkg::FUNC_UNW, 8'h00, 6'd0, 48'd300, 6'd0);
    send_event(csop_pkg::FUNC_OP, 8'h80, 6'd0, 48'd0, 6'd0);
    send_event(csop_pkg::FUNC_OP, 8'h80, 6'd0, 48'd0, 6'd0);
  endtask

  task automatic test_full_stack();
    repeat (35) send_event(csop_pkg::FUNC_ENT, 8'($urandom()), 6'($urandom()), tick(),
                           6'($urandom()));
    send_event(csop_pkg::FUNC_UNW, 8'($urandom()), 6'($urandom()), tick(), 6'd0);
  endtask

  task automatic test_random(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)
        send_event(csop_pkg::FUNC_OP, 8'($urandom()), 6'($urandom()), rand48(),
                   6'($urandom()));
      else if (sel < 65 || depth == 0 && sel < 80)
        send_event(csop_pkg::FUNC_ENT, 8'($urandom()),
                   ($urandom_range(0, 7) == 0) ? 6'($urandom())
                                               : 6'($urandom_range(0, 5)),
                   tick(), 6'($urandom()));
      else if (sel < 85)
        send_event(csop_pkg::FUNC_EXIT, 8'($urandom()),
                   (depth > 0 && $urandom_range(0, 5) != 0) ? frame_id[depth-1]
                                                            : 6'($urandom()),
                   tick(), 6'($urandom()));
      else if (sel < 95)
        send_event(csop_pkg::FUNC_UNW, 8'($urandom()), 6'($urandom()), tick(),
                   (depth > 0) ? 6'($urandom_range(0, depth - 1))
                               : 6'($urandom_range(0, 63)));
      else
        send_event(csop_pkg::FUNC_UNW, 8'($urandom()), 6'($urandom()), tick(),
                   6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    rx_cnt = 0;
    errors = 0;
    burst_left = 0;
    now_ts = MAX48 - 48'd5000;
    full_mode = 1'b0;
    prev_op = '0;
    prev_seen = 1'b0;
    depth = 0;
    foreach (op_count[i]) op_count[i] = '0;
    foreach (calls[i]) begin
      calls[i] = '0;
      tot_time[i] = '0;
      self_acc[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    drain();
    write_mode(1'b1);
    test_directed();
    test_random(130);
    drain();
    write_mode(1'b0);
    test_random(130);
    drain();
    write_mode(1'b1);
    test_full_stack();
    test_random(130);

    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #30000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
